[hw/rtl/pbra_pkg.sv]
// Shared types and constants for the pooled bump range allocator.
// No dependencies; every other file in hw/rtl depends on this package.
package pbra_pkg;

   localparam int CMD_W      = 1;
   localparam int COUNT_W    = 24;
   localparam int TAG_W      = 8;
   localparam int STATUS_W   = 2;
   localparam int SLOT_IDX_W = 4;
   localparam int OFFSET_W   = 24;
   localparam int LIMIT_W    = 29;
   localparam int CAP_W      = 25;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 29'd268435456;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOCATE = 1'b0,
      CMD_REFILL   = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED  = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_NO_SPACE = 2'd2,
      STATUS_REFILLED = 2'd3
   } status_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [CAP_W-1:0] capacity;
      logic [CAP_W-1:0] available;
   } slot_entry_type;

   typedef struct packed {
      status_type            status;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [OFFSET_W-1:0]   start_offset;
      logic                  opened_new;
   } rsp_word_type;

endpackage

[hw/rtl/pbra_channels.sv]
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on pbra_pkg for field widths.
interface pbra_req_if;
   logic                              valid;
   logic                              ready;
   logic [pbra_pkg::CMD_W-1:0]        command;
   logic [pbra_pkg::COUNT_W-1:0]      count;
   logic [pbra_pkg::TAG_W-1:0]        format_tag;

   modport source (output valid, command, count, format_tag, input ready);
   modport sink   (input valid, command, count, format_tag, output ready);
endinterface

interface pbra_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pbra_pkg::STATUS_W-1:0]     status;
   logic [pbra_pkg::SLOT_IDX_W-1:0]   slot_index;
   logic [pbra_pkg::OFFSET_W-1:0]     start_offset;
   logic                              opened_new;

   modport source (output valid, status, slot_index, start_offset, opened_new, input ready);
   modport sink   (input valid, status, slot_index, start_offset, opened_new, output ready);
endinterface

[hw/rtl/pbra_slot_ram.sv]
// Slot table memory: one write port, one read port, registered read data.
// Depends on pbra_pkg for the slot entry layout.
module pbra_slot_ram #(
   parameter int SLOTS  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                     clock,
   input  logic [ADDR_W-1:0]        rd_addr,
   output pbra_pkg::slot_entry_type rd_data,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  pbra_pkg::slot_entry_type wr_data
);
   import pbra_pkg::*;

   slot_entry_type slot_mem [SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pbra_round_unit.sv]
// Rounds a request count up to a multiple of the slot grain.
// Depends on pbra_pkg; a non power of two grain uses a reciprocal multiply.
module pbra_round_unit #(
   parameter int GRAIN = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pbra_pkg::COUNT_W-1:0] count,
   output logic                         done,
   output logic [pbra_pkg::CAP_W-1:0]   capacity
);
   import pbra_pkg::*;

   localparam logic [CAP_W-1:0] GRAIN_V    = CAP_W'(GRAIN);
   localparam bit               GRAIN_POW2 = ((GRAIN & (GRAIN - 1)) == 0);

   logic [CAP_W-1:0] num_ff;
   logic [CAP_W-1:0] num_in;

   // count + GRAIN - 1 never overflows 25 bits
   assign num_in = CAP_W'(count) + GRAIN_V - CAP_W'(1);

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num_in;
      end
   end

   generate
      if (GRAIN_POW2) begin : g_mask
         logic done_ff;
         logic done_in;

         assign done_in = start ? 1'b1 : done_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= done_in;
            end
         end

         assign done     = done_ff;
         assign capacity = num_ff & ~(GRAIN_V - CAP_W'(1));
      end else begin : g_recip
         localparam int                SHIFT   = CAP_W + $clog2(GRAIN);
         localparam int                PROD_W  = 2 * CAP_W + 1;
         localparam logic [63:0]       RECIP   = (64'd1 << SHIFT) / 64'(GRAIN);
         localparam logic [PROD_W-1:0] RECIP_V = PROD_W'(RECIP);

         logic [PROD_W-1:0] prod_ff;
         logic [CAP_W-1:0]  quot_est;
         logic [CAP_W-1:0]  base_ff;
         logic [CAP_W-1:0]  rem;
         logic [1:0]        step_ff;
         logic [1:0]        step_in;

         // quotient estimate is low by at most one grain
         assign quot_est = CAP_W'(prod_ff >> SHIFT);
         assign step_in  = start ? 2'd2 :
                           ((step_ff != 2'd0) ? (step_ff - 2'd1) : step_ff);

         always_ff @(posedge clock) begin
            if (reset) begin
               step_ff <= 2'd0;
            end else begin
               step_ff <= step_in;
            end
         end

         always_ff @(posedge clock) begin
            prod_ff <= PROD_W'(num_ff) * RECIP_V;
            base_ff <= quot_est * GRAIN_V;
         end

         // add back the missing grain when the estimate came out low
         assign rem      = num_ff - base_ff;
         assign done     = (step_ff == 2'd0);
         assign capacity = (rem >= GRAIN_V) ? (base_ff + GRAIN_V) : base_ff;
      end
   endgenerate

endmodule

[hw/rtl/pooled_bump_range_allocator_unit.sv]
// Top level of the pooled bump range allocator: control sequencer, refill
// marks and output register. Depends on pbra_pkg, pbra_channels,
// pbra_slot_ram and pbra_round_unit.
//
//   channel  dir  signals                                   word
//   req      in   valid ready command count format_tag      one request
//   rsp      out  valid ready status slot_index             one response
//                 start_offset opened_new
//   csr      in   csr_write_enable csr_write_data           storage limit
//
// An allocation scans open slots in index order through the slot memory, one
// read per cycle. Refill and zero count requests skip the search.
// Reset clears control state only.
// A new request is taken while a response waits on a stalled rsp channel.
module pooled_bump_range_allocator_unit #(
   parameter int SLOTS = 16,
   parameter int GRAIN = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   pbra_req_if.sink                     req_chan,
   pbra_rsp_if.source                   rsp_chan,
   input  logic                         csr_write_enable,
   input  logic [pbra_pkg::LIMIT_W-1:0] csr_write_data
);
   import pbra_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_OPEN   = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [LIMIT_W-1:0]   storage_ff, storage_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [SLOTS-1:0]     fresh_ff, fresh_in;
   rsp_word_type         res_ff, res_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_word_type         out_word_ff, out_word_in;

   logic                 accept;
   logic                 out_free;
   slot_entry_type       rd_data;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   slot_entry_type       wr_data;
   logic                 round_done;
   logic [CAP_W-1:0]     round_cap;
   logic [CAP_W-1:0]     avail_eff;
   logic                 hit;
   logic [LIMIT_W:0]     storage_sum;

   pbra_slot_ram #(
      .SLOTS  (SLOTS),
      .ADDR_W (IDX_W)
   ) u_slot_ram (
      .clock   (clock),
      .rd_addr (rd_ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   pbra_round_unit #(
      .GRAIN (GRAIN)
   ) u_round (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .count    (req_chan.count),
      .done     (round_done),
      .capacity (round_cap)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !out_valid_ff || rsp_chan.ready;

   // a refilled slot reads back as full until its next grant
   assign avail_eff   = fresh_ff[chk_idx_ff] ? rd_data.capacity : rd_data.available;
   assign hit         = chk_valid_ff && (rd_data.tag == tag_ff)
                        && (avail_eff >= CAP_W'(count_ff));
   assign storage_sum = {1'b0, storage_ff} + (LIMIT_W + 1)'(round_cap);

   always_comb begin
      state_in     = state_ff;
      tag_in       = tag_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      used_in      = used_ff;
      storage_in   = storage_ff;
      fresh_in     = fresh_ff;
      res_in       = res_ff;
      wr_en        = 1'b0;
      wr_addr      = chk_idx_ff;
      wr_data      = rd_data;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_word_in  = out_word_ff;
      limit_in     = csr_write_enable ? csr_write_data : limit_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tag_in    = req_chan.format_tag;
               count_in  = req_chan.count;
               rd_ptr_in = '0;
               res_in    = '0;
               if (req_chan.command == CMD_REFILL) begin
                  fresh_in      = '1;
                  res_in.status = STATUS_REFILLED;
                  state_in      = ST_DONE;
               end else if (req_chan.count == '0) begin
                  res_in.status = STATUS_EMPTY;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end

         ST_SEARCH: begin
            if (hit) begin
               wr_en                = 1'b1;
               wr_addr              = chk_idx_ff;
               wr_data.tag          = rd_data.tag;
               wr_data.capacity     = rd_data.capacity;
               wr_data.available    = avail_eff - CAP_W'(count_ff);
               fresh_in[chk_idx_ff] = 1'b0;
               res_in.status        = STATUS_GRANTED;
               res_in.slot_index    = SLOT_IDX_W'(chk_idx_ff);
               res_in.start_offset  = OFFSET_W'(rd_data.capacity - avail_eff);
               res_in.opened_new    = 1'b0;
               state_in             = ST_DONE;
            end else if (rd_ptr_ff < used_ff) begin
               // issue the next read; its data is checked next cycle
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_ptr_ff[IDX_W-1:0];
               rd_ptr_in    = rd_ptr_ff + CNT_W'(1);
            end else begin
               state_in = ST_OPEN;
            end
         end

         ST_OPEN: begin
            if (round_done) begin
               if ((used_ff == CNT_W'(SLOTS)) || (storage_sum > {1'b0, limit_ff})) begin
                  res_in.status = STATUS_NO_SPACE;
               end else begin
                  wr_en                         = 1'b1;
                  wr_addr                       = used_ff[IDX_W-1:0];
                  wr_data.tag                   = tag_ff;
                  wr_data.capacity              = round_cap;
                  wr_data.available             = round_cap - CAP_W'(count_ff);
                  fresh_in[used_ff[IDX_W-1:0]]  = 1'b0;
                  used_in                       = used_ff + CNT_W'(1);
                  storage_in                    = storage_sum[LIMIT_W-1:0];
                  res_in.status                 = STATUS_GRANTED;
                  res_in.slot_index             = SLOT_IDX_W'(used_ff);
                  res_in.start_offset           = '0;
                  res_in.opened_new             = 1'b1;
               end
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // hold until the output register can take the word
            if (out_free) begin
               out_word_in  = res_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_valid_ff <= 1'b0;
         used_ff      <= '0;
         storage_ff   <= '0;
         limit_ff     <= LIMIT_RESET;
         fresh_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         used_ff      <= used_in;
         storage_ff   <= storage_in;
         limit_ff     <= limit_in;
         fresh_ff     <= fresh_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff      <= tag_in;
      count_ff    <= count_in;
      rd_ptr_ff   <= rd_ptr_in;
      chk_idx_ff  <= chk_idx_in;
      res_ff      <= res_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_word_ff.status;
   assign rsp_chan.slot_index   = out_word_ff.slot_index;
   assign rsp_chan.start_offset = out_word_ff.start_offset;
   assign rsp_chan.opened_new   = out_word_ff.opened_new;

endmodule

[verif/tb.sv]
// Self-checking bench for pooled_bump_range_allocator_unit: checks every response against
// an in-bench model of the slot table, with random idling on both channels.
// Depends on pbra_pkg, pbra_channels and the allocator RTL.
module tb;
   import pbra_pkg::*;

   localparam int SLOTS        = 16;
   localparam int GRAIN        = 65536;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 3 * SLOTS + 30;

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [LIMIT_W-1:0]  csr_write_data;

   pbra_req_if req_bus ();
   pbra_rsp_if rsp_bus ();

   pooled_bump_range_allocator_unit #(
      .SLOTS (SLOTS),
      .GRAIN (GRAIN)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // slot table as the bench sees it
   logic               slot_open    [SLOTS];
   logic [TAG_W-1:0]   slot_tag_q   [SLOTS];
   logic [CAP_W-1:0]   slot_cap_q   [SLOTS];
   logic [CAP_W-1:0]   slot_avail_q [SLOTS];
   int unsigned        open_slots = 0;
   logic [31:0]        storage_used_q = '0;
   logic [LIMIT_W-1:0] storage_limit_q = LIMIT_RESET;

   rsp_word_type       pending_grants [$];
   int                 error_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   logic               hold_request = 1'b0;
   int                 hold_left = 0;

   logic [TAG_W-1:0]   tag_pool [5] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h3C};
   logic [COUNT_W-1:0] edge_counts [6] =
      '{24'd1, 24'd65535, 24'd65536, 24'd65537, 24'hFFFFFF, 24'd131072};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // first-fit search, open on miss, bump the chosen slot; refill and empty return early
   function automatic rsp_word_type compute_grant(input command_type cmd,
                                                  input logic [COUNT_W-1:0] cnt,
                                                  input logic [TAG_W-1:0] tag);
      rsp_word_type word;
      int           pick;
      int           i;
      logic [31:0]  cap;
      word.status       = STATUS_GRANTED;
      word.slot_index   = '0;
      word.start_offset = '0;
      word.opened_new   = 1'b0;
      pick = -1;
      cap  = ((32'(cnt) + 32'(GRAIN - 1)) / 32'(GRAIN)) * 32'(GRAIN);
      if (cmd == CMD_REFILL) begin
         for (i = 0; i < SLOTS; i++)
            if (slot_open[i])
               slot_avail_q[i] = slot_cap_q[i];
         word.status = STATUS_REFILLED;
         return word;
      end
      if (cnt == '0) begin
         word.status = STATUS_EMPTY;
         return word;
      end
      for (i = 0; i < SLOTS; i++) begin
         if (pick < 0 && slot_open[i] && slot_tag_q[i] == tag && slot_avail_q[i] >= cnt)
            pick = i;
      end
      if (pick < 0) begin
         if (open_slots >= SLOTS || storage_used_q + cap > 32'(storage_limit_q)) begin
            word.status = STATUS_NO_SPACE;
            return word;
         end
         pick               = open_slots;
         slot_open[pick]    = 1'b1;
         slot_tag_q[pick]   = tag;
         slot_cap_q[pick]   = CAP_W'(cap);
         slot_avail_q[pick] = CAP_W'(cap);
         open_slots++;
         storage_used_q += cap;
         word.opened_new = 1'b1;
      end
      word.slot_index   = SLOT_IDX_W'(pick);
      word.start_offset = OFFSET_W'(slot_cap_q[pick] - slot_avail_q[pick]);
      slot_avail_q[pick] -= CAP_W'(cnt);
      return word;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $time);
      error_count++;
   endtask

   // hold valid until the word is taken, then predict its response
   task automatic send_word(input command_type cmd, input logic [COUNT_W-1:0] cnt,
                            input logic [TAG_W-1:0] tag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.count      <= cnt;
      req_bus.format_tag <= tag;
      do @(posedge clock); while (!req_bus.ready);
      pending_grants.insert(pending_grants.size(), compute_grant(cmd, cnt, tag));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_grants.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_storage_limit(input logic [LIMIT_W-1:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      storage_limit_q = value;
   endtask

   // mostly known tags and modest counts so slots get reused across refills
   task automatic send_random_word();
      int                 sel;
      logic [COUNT_W-1:0] cnt;
      logic [TAG_W-1:0]   tag;
      sel = $urandom_range(99);
      tag = ($urandom_range(99) < 96) ? tag_pool[$urandom_range(4)] : TAG_W'($urandom);
      if (sel < 8) begin
         send_word(CMD_REFILL, COUNT_W'($urandom), TAG_W'($urandom));
      end else if (sel < 13) begin
         send_word(CMD_ALLOCATE, '0, TAG_W'($urandom));
      end else begin
         sel = $urandom_range(99);
         if (sel < 55)
            cnt = COUNT_W'($urandom_range(1, 4096));
         else if (sel < 85)
            cnt = COUNT_W'($urandom_range(1, 200000));
         else if (sel < 95)
            cnt = COUNT_W'($urandom_range(1, 24'hFFFFFF));
         else
            cnt = edge_counts[$urandom_range(5)];
         send_word(CMD_ALLOCATE, cnt, tag);
      end
   endtask

   task automatic test_directed_ranges();
      send_idle_pct = 25;
      recv_idle_pct = 54;
      send_word(CMD_REFILL, '0, '0);
      send_word(CMD_ALLOCATE, '0, 8'h00);
      send_word(CMD_ALLOCATE, '0, 8'hFF);
      send_word(CMD_ALLOCATE, 24'd1, 8'h00);
      send_word(CMD_ALLOCATE, 24'd65535, 8'h00);
      // slot 0 is exhausted, so this opens slot 1
      send_word(CMD_ALLOCATE, 24'd1, 8'h00);
      send_word(CMD_ALLOCATE, 24'd65536, 8'hA5);
      send_word(CMD_ALLOCATE, 24'd65537, 8'h5A);
      send_word(CMD_ALLOCATE, 24'hFFFFFF, 8'hFF);
      send_word(CMD_ALLOCATE, 24'd1, 8'hFF);
      // refill ignores its payload
      send_word(CMD_REFILL, 24'hFFFFFF, 8'hFF);
      send_word(CMD_ALLOCATE, 24'hFFFFFF, 8'hFF);
      send_word(CMD_ALLOCATE, 24'd1, 8'h00);
   endtask

   task automatic test_storage_limit();
      set_storage_limit('0);
      send_word(CMD_ALLOCATE, 24'd1, 8'h11);
      send_word(CMD_ALLOCATE, 24'd1, 8'h00);
      // new slot lands exactly on the limit, the next one goes past it
      set_storage_limit(LIMIT_W'(storage_used_q + 32'(GRAIN)));
      send_word(CMD_ALLOCATE, 24'd65536, 8'h22);
      send_word(CMD_ALLOCATE, 24'd1, 8'h33);
      set_storage_limit('1);
      send_word(CMD_ALLOCATE, 24'd1, 8'h33);
   endtask

   task automatic test_random_mix(input int n_items, input int send_pct, input int recv_pct);
      int n;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (n = 0; n < n_items; n++)
         send_random_word();
   endtask

   // stall the response side long enough for the request side to back up
   task automatic test_backpressure();
      int n;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      for (n = 0; n < 40; n++)
         send_random_word();
   endtask

   task automatic test_table_full();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_storage_limit('1);
      while (open_slots < SLOTS)
         send_word(CMD_ALLOCATE, 24'hFFFFFF, 8'hC3);
      send_word(CMD_ALLOCATE, 24'hFFFFFF, 8'hC3);
      send_word(CMD_ALLOCATE, 24'd1, 8'h77);
   endtask

   always @(posedge clock) begin
      if (hold_request)
         hold_left <= HOLD_CYCLES;
      else if (hold_left > 0)
         hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("response with nothing pending, status", 32'(rsp_bus.status), 0);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
            if (rsp_bus.slot_index !== want.slot_index)
               report_mismatch("slot_index", 32'(rsp_bus.slot_index), 32'(want.slot_index));
            if (rsp_bus.start_offset !== want.start_offset)
               report_mismatch("start_offset", 32'(rsp_bus.start_offset),
                               32'(want.start_offset));
            if (rsp_bus.opened_new !== want.opened_new)
               report_mismatch("opened_new", 32'(rsp_bus.opened_new), 32'(want.opened_new));
         end
      end
      rsp_bus.ready <= (hold_left == 0) && !hold_request &&
                       ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      for (int i = 0; i < SLOTS; i++)
         slot_open[i] = 1'b0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.command    <= CMD_ALLOCATE;
      req_bus.count      <= '0;
      req_bus.format_tag <= '0;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_ranges();
      test_storage_limit();
      test_random_mix(180, 25, 54);
      set_storage_limit(LIMIT_W'(storage_used_q + 32'($urandom_range(0, 3)) * 32'(GRAIN)));
      test_random_mix(180, 54, 25);
      test_backpressure();
      test_table_full();
      set_storage_limit(LIMIT_RESET);
      test_random_mix(180, 0, 0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
